### hw/rtl/mvst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvst_pkg
// Shared types and constants for the multi-voice square tone sequencer.
// ----------------------------------------------------------------------------
package mvst_pkg;

  localparam int VOICES          = 4;
  localparam int NOTES_PER_VOICE = 256;
  localparam int VW              = $clog2(VOICES);
  localparam int SW              = $clog2(NOTES_PER_VOICE);
  localparam int AW              = VW + SW;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RATE  = 2'd0,
    REG_TEMPO = 2'd1,
    REG_MULT  = 2'd2,
    REG_VOICE = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_NOTE,
    ST_THR,
    ST_DIV,
    ST_UPD,
    ST_MIX,
    ST_MIXDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  octave;
    logic [15:0] tone;
    logic [11:0] len;
  } note_t;

endpackage

### hw/rtl/multi_voice_square_tone_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_square_tone_sequencer_unit
// Phase-accumulator square synth over up to four voices with note sequencing.
// ----------------------------------------------------------------------------
// Load and start are taken even while a tick result waits for transfer. A
// sample tick steps each mixed voice in turn through one shared restoring
// divider, one quotient bit per cycle over the 52-bit dividend
// tone << (octave+29); a finished voice skips the division. A mix division
// and the output state follow. If the previous result has not been
// transferred yet, the tick waits in its output state and no new item is
// taken. Note memory needs no clearing after reset.
module multi_voice_square_tone_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_voice,
  input  logic [7:0]  in_note_slot,
  input  logic [2:0]  in_octave,
  input  logic [15:0] in_tone_q4,
  input  logic [11:0] in_note_length_q4,
  input  logic [8:0]  in_note_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_duty_permyriad,
  output logic        out_all_done
);
  import mvst_pkg::*;

  logic [17:0] rate_r;
  logic [9:0]  tempo_r;
  logic [4:0]  mult_r;
  logic [2:0]  vcnt_r;

  logic [31:0] phase_r [VOICES];
  logic        sq_r    [VOICES];
  logic [39:0] beat_r  [VOICES];
  logic [8:0]  pos_r   [VOICES];
  logic [8:0]  tot_r   [VOICES];

  note_t       mem [VOICES*NOTES_PER_VOICE];
  note_t       rd_r;

  state_t      st_r;
  logic [VW-1:0] v_r;
  logic [2:0]  n_r;
  logic [5:0]  cnt_r;
  // shared restoring divider: remainder, dividend shift, quotient
  logic [18:0] rem_r;
  logic [51:0] dvd_r;
  logic [31:0] quo_r;
  logic [47:0] thr_r;
  logic [2:0]  sum_r;
  logic        done_r;
  logic        ov_r;
  logic [13:0] duty_r;

  logic [17:0] erate;
  logic [18:0] trial;
  logic        fits;
  logic        running;
  logic [8:0]  cnt_sat;
  logic [2:0]  nv;
  logic        out_load;

  assign erate = (rate_r == '0) ? 18'd1 : rate_r;
  assign trial = {rem_r[17:0], dvd_r[51]};
  assign fits  = trial >= {1'b0, erate};
  assign running = (pos_r[v_r] < tot_r[v_r]);
  assign cnt_sat = (in_note_count > 9'(NOTES_PER_VOICE)) ? 9'(NOTES_PER_VOICE)
                                                          : in_note_count;
  always_comb begin
    nv = vcnt_r;
    if (nv == 3'd0) nv = 3'd1;
    if (nv > 3'(VOICES)) nv = 3'(VOICES);
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_duty_permyriad = duty_r;
  assign out_load  = (st_r == ST_OUT) && (!ov_r || out_ready);

  // memory port
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_command == CMD_LOAD)
      mem[{in_voice[VW-1:0], in_note_slot[SW-1:0]}] <=
        '{octave: in_octave, tone: in_tone_q4, len: in_note_length_q4};
    rd_r <= mem[{v_r, pos_r[v_r][SW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 18'd8000; tempo_r <= 10'd120; mult_r <= 5'd4; vcnt_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_RATE:  rate_r  <= cfg_data;
        REG_TEMPO: tempo_r <= cfg_data[9:0];
        REG_MULT:  mult_r  <= cfg_data[4:0];
        REG_VOICE: vcnt_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [14:0] bstep;
  logic [39:0] bsum;
  assign bstep = 15'(tempo_r) * 15'(mult_r);
  assign bsum  = beat_r[v_r] + {21'd0, bstep, 4'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0; sq_r[i] <= 1'b0; beat_r[i] <= '0;
        pos_r[i] <= '0; tot_r[i] <= '0;
      end
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_command == CMD_START) begin
              tot_r[in_voice]   <= cnt_sat;
              pos_r[in_voice]   <= '0;
              phase_r[in_voice] <= '0;
              sq_r[in_voice]    <= 1'b0;
              beat_r[in_voice]  <= '0;
            end else if (in_command == CMD_TICK) begin
              v_r <= '0; n_r <= nv; sum_r <= '0; done_r <= 1'b1;
              st_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          st_r <= running ? ST_NOTE : ST_MIX;
        end
        ST_NOTE: begin
          // threshold len*60*rate, done as len*rate then *60 via shifts
          thr_r <= 48'(30'(rd_r.len) * 30'(erate));
          st_r  <= ST_THR;
        end
        ST_THR: begin
          thr_r <= (thr_r << 6) - (thr_r << 2);
          dvd_r <= 52'(rd_r.tone) << (6'd29 + 6'(rd_r.octave));
          rem_r <= '0; quo_r <= '0; cnt_r <= 6'd51; st_r <= ST_DIV;
        end
        ST_DIV: begin
          // dividend = tone << (oct+29), 52 bits, low 32 quotient bits kept
          rem_r <= fits ? (trial - {1'b0, erate}) : trial;
          quo_r <= {quo_r[30:0], fits};
          dvd_r <= {dvd_r[50:0], 1'b0};
          if (cnt_r == '0) st_r <= ST_UPD;
          cnt_r <= cnt_r - 6'd1;
        end
        ST_UPD: begin
          phase_r[v_r] <= phase_r[v_r] + quo_r;
          if ({1'b0, phase_r[v_r]} + {1'b0, quo_r} > 33'hFFFF_FFFF)
            sq_r[v_r] <= ~sq_r[v_r];
          if ({8'd0, bsum} >= thr_r) begin
            pos_r[v_r] <= pos_r[v_r] + 9'd1; beat_r[v_r] <= '0;
          end else beat_r[v_r] <= bsum;
          st_r <= ST_MIX;
        end
        ST_MIX: begin
          sum_r <= sum_r + 3'(sq_r[v_r]);
          if (pos_r[v_r] < tot_r[v_r]) done_r <= 1'b0;
          if (3'(v_r) + 3'd1 == n_r) begin
            dvd_r <= 52'(({3'd0, sum_r + 3'(sq_r[v_r])}) * 17'd10000) << 35;
            rem_r <= '0; quo_r <= '0; cnt_r <= 6'd16; st_r <= ST_MIXDIV;
          end else begin
            v_r <= v_r + 1'b1; st_r <= ST_RD;
          end
        end
        ST_MIXDIV: begin
          begin
            logic [18:0] t2;
            logic        f2;
            t2 = {rem_r[17:0], dvd_r[51]};
            f2 = t2 >= {16'd0, n_r};
            rem_r <= f2 ? (t2 - {16'd0, n_r}) : t2;
            quo_r <= {quo_r[30:0], f2};
          end
          dvd_r <= {dvd_r[50:0], 1'b0};
          if (cnt_r == '0) st_r <= ST_OUT;
          cnt_r <= cnt_r - 6'd1;
        end
        ST_OUT: begin
          // waits here while the previous result is still not transferred
          if (out_load) begin
            duty_r <= (quo_r[16:0] < 17'd100) ? 14'd100 :
                      (quo_r[16:0] > 17'd9900) ? 14'd9900 : quo_r[13:0];
            out_all_done <= done_r;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == ST_IDLE) else $error("ready outside idle");
  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> $stable(duty_r) && $stable(out_all_done))
    else $error("result changed while waiting");
  a_duty_rng: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> duty_r >= 14'd100 && duty_r <= 14'd9900) else $error("duty range");
  a_nv: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MIX |-> 3'(v_r) < n_r) else $error("voice index past count");

endmodule

### verif/multi_voice_square_tone_sequencer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_square_tone_sequencer_unit_checker
// Watches the config port and both channels, keeps a cycle-free model of the
// voices, and compares each transferred tick result with the oldest prediction.
// ----------------------------------------------------------------------------
module multi_voice_square_tone_sequencer_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_voice,
  input  logic [7:0]  in_note_slot,
  input  logic [2:0]  in_octave,
  input  logic [15:0] in_tone_q4,
  input  logic [11:0] in_note_length_q4,
  input  logic [8:0]  in_note_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [13:0] out_duty_permyriad,
  input  logic        out_all_done,
  output int          mismatches,
  output int          pending
);
  import mvst_pkg::*;

  typedef struct packed {
    logic [13:0] duty;
    logic        done;
  } mix_t;

  localparam longint unsigned BEAT_MASK = 64'hFF_FFFF_FFFF;

  note_t              notes [VOICES][NOTES_PER_VOICE];
  logic [31:0]        phase [VOICES];
  logic               sq    [VOICES];
  longint unsigned    beat  [VOICES];
  int unsigned        pos   [VOICES];
  int unsigned        total [VOICES];
  logic [17:0]        rate_r;
  logic [9:0]         tempo_r;
  logic [4:0]         mult_r;
  logic [2:0]         vcount_r;
  mix_t               expected_mix [$];

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  task automatic advance_voice(input int v);
    note_t           nt;
    longint unsigned rate, inc, thr;
    logic [31:0]     nxt;
    if (pos[v] >= total[v]) return;
    nt   = notes[v][pos[v]];
    rate = (rate_r == 0) ? 1 : rate_r;
    inc  = (longint'(nt.tone) << (nt.octave + 29)) / rate;
    nxt  = phase[v] + inc[31:0];
    if (nxt < phase[v]) sq[v] = ~sq[v];
    phase[v] = nxt;
    beat[v] = (beat[v] + 16 * longint'(tempo_r) * longint'(mult_r)) & BEAT_MASK;
    thr = longint'(nt.len) * 60 * rate;
    if (beat[v] >= thr) begin
      pos[v]++;
      beat[v] = 0;
    end
  endtask

  task automatic predict_mix();
    int   n, sum, duty;
    mix_t m;
    n = (vcount_r == 0) ? 1 : ((vcount_r > VOICES) ? VOICES : vcount_r);
    sum = 0;
    m.done = 1'b1;
    for (int i = 0; i < n; i++) begin
      advance_voice(i);
      sum += sq[i];
      if (pos[i] < total[i]) m.done = 1'b0;
    end
    duty = sum * 10000 / n;
    if (duty < 100) duty = 100;
    if (duty > 9900) duty = 9900;
    m.duty = duty[13:0];
    expected_mix.push_back(m);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase[i] = 0; sq[i] = 0; beat[i] = 0; pos[i] = 0; total[i] = 0;
      end
      rate_r = 18'd8000; tempo_r = 10'd120; mult_r = 5'd4; vcount_r = 3'd1;
      expected_mix.delete();
    end else begin
      if (cfg_we) begin
        case (reg_t'(cfg_index))
          REG_RATE:  rate_r   = cfg_data;
          REG_TEMPO: tempo_r  = cfg_data[9:0];
          REG_MULT:  mult_r   = cfg_data[4:0];
          REG_VOICE: vcount_r = cfg_data[2:0];
        endcase
      end
      // a result transferred now belongs to an earlier item
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          report("unexpected result, duty", -1, out_duty_permyriad);
        end else begin
          mix_t m;
          m = expected_mix.pop_front();
          if (out_duty_permyriad !== m.duty) report("duty", m.duty, out_duty_permyriad);
          if (out_all_done !== m.done) report("all_done", m.done, out_all_done);
        end
      end
      if (in_valid && in_ready) begin
        case (cmd_t'(in_command))
          CMD_LOAD:
            notes[in_voice][in_note_slot] =
              '{in_octave, in_tone_q4, in_note_length_q4};
          CMD_START: begin
            total[in_voice] = (in_note_count > NOTES_PER_VOICE) ? NOTES_PER_VOICE
                                                                : in_note_count;
            pos[in_voice] = 0; phase[in_voice] = 0; sq[in_voice] = 0; beat[in_voice] = 0;
          end
          CMD_TICK: predict_mix();
          default: ;
        endcase
      end
    end
    pending = expected_mix.size();
  end

  initial begin
    mismatches = 0;
    pending = 0;
  end

endmodule

### verif/multi_voice_square_tone_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_square_tone_sequencer_unit_tb
// Preloads the first note slots, runs directed then random load/start/tick
// traffic over several register settings and idle patterns, and reports.
// ----------------------------------------------------------------------------
module multi_voice_square_tone_sequencer_unit_tb;
  import mvst_pkg::*;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [17:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  in_command, in_voice;
  logic [7:0]  in_note_slot;
  logic [2:0]  in_octave;
  logic [15:0] in_tone_q4;
  logic [11:0] in_note_length_q4;
  logic [8:0]  in_note_count;
  logic        out_valid, out_ready;
  logic [13:0] out_duty_permyriad;
  logic        out_all_done;
  int          mismatches, pending;

  int send_idle_pct, stall_pct;
  int hold_reqs, hold_served, hold_left;

  multi_voice_square_tone_sequencer_unit u_dut (.*);

  multi_voice_square_tone_sequencer_unit_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL multi_voice_square_tone_sequencer_unit");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs counted here
  initial begin
    hold_served = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send(input cmd_t cmd, input logic [1:0] v, input logic [7:0] slot,
                      input logic [2:0] oct, input logic [15:0] tone,
                      input logic [11:0] len, input logic [8:0] cnt);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd; in_voice <= v; in_note_slot <= slot; in_octave <= oct;
    in_tone_q4 <= tone; in_note_length_q4 <= len; in_note_count <= cnt;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic configure(input logic [17:0] rate, input logic [17:0] tempo,
                           input logic [17:0] mult, input logic [17:0] vc);
    cfg_we <= 1'b1; cfg_index <= REG_RATE;  cfg_data <= rate;  @(posedge clk);
    cfg_index <= REG_TEMPO; cfg_data <= tempo; @(posedge clk);
    cfg_index <= REG_MULT;  cfg_data <= mult;  @(posedge clk);
    cfg_index <= REG_VOICE; cfg_data <= vc;    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [7:0]  slot;
    logic [11:0] len;
    logic [8:0]  cnt;
    r = $urandom_range(99);
    if (r < 55) begin
      send(CMD_TICK, 2'($urandom), 8'($urandom), 3'($urandom), 16'($urandom),
           12'($urandom), 9'($urandom));
    end else if (r < 72) begin
      // starts stay within the preloaded slots
      cnt = ($urandom_range(9) < 8) ? 9'($urandom_range(6)) : 9'($urandom_range(8));
      send(CMD_START, 2'($urandom), 8'($urandom), 3'($urandom), 16'($urandom),
           12'($urandom), cnt);
    end else if (r < 95) begin
      slot = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
      len = ($urandom_range(9) != 0) ? 12'($urandom_range(4)) : 12'($urandom_range(4095));
      send(CMD_LOAD, 2'($urandom), slot, 3'($urandom), 16'($urandom), len, 9'($urandom));
    end else begin
      send(CMD_NONE, 2'($urandom), 8'($urandom), 3'($urandom), 16'($urandom),
           12'($urandom), 9'($urandom));
    end
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (items) random_item();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_RATE; cfg_data = '0;
    in_valid = 1'b0; in_command = CMD_NONE; in_voice = '0; in_note_slot = '0;
    in_octave = '0; in_tone_q4 = '0; in_note_length_q4 = '0; in_note_count = '0;
    send_idle_pct = 0; stall_pct = 0; hold_reqs = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first eight slots of every voice get a note; no voice plays past them
    for (int v = 0; v < VOICES; v++)
      for (int s = 0; s < 8; s++)
        send(CMD_LOAD, 2'(v), 8'(s), 3'($urandom), 16'($urandom),
             12'($urandom_range(3)), 9'($urandom));

    // directed, reset settings
    send(CMD_TICK, 0, 0, 0, 0, 0, 0);              // all voices idle: done, duty floor
    send(CMD_LOAD, 0, 0, 3'd7, 16'hFFFF, 12'd0, 0); // max tone, zero length
    send(CMD_LOAD, 0, 1, 3'd0, 16'd0, 12'd4095, 0);
    send(CMD_LOAD, 3, 255, 3'd7, 16'hFFFF, 12'd4095, 9'h1FF);
    send(CMD_START, 0, 0, 0, 0, 0, 9'd2);
    repeat (4) send(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send(CMD_START, 0, 0, 0, 0, 0, 9'd0);
    send(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send(CMD_START, 0, 0, 0, 0, 0, 9'h1FF);         // saturates to full voice
    send(CMD_NONE, 3, 8'hFF, 3'd7, 16'hFFFF, 12'hFFF, 9'h1FF);
    repeat (3) send(CMD_TICK, 3, 8'hFF, 3'd7, 16'hFFFF, 12'hFFF, 9'h1FF);
    send(CMD_START, 0, 0, 0, 0, 0, 9'd256);
    send(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send(CMD_START, 0, 0, 0, 0, 0, 9'd0);           // stop voice 0 before random traffic
    drain();

    configure(18'd8000, 18'd120, 18'd4, 18'd1);
    run_phase(60, 0, 0);
    hold_reqs++;                                   // long receiver hold, input keeps offering
    run_phase(20, 0, 0);
    drain();

    configure(18'd1, 18'd1000, 18'd16, 18'd4);
    send(CMD_START, 1, 0, 0, 0, 0, 9'd5);
    send(CMD_START, 2, 0, 0, 0, 0, 9'd5);
    run_phase(80, 57, 0);
    drain();

    configure(18'd200000, 18'd1, 18'd1, 18'd2);
    run_phase(40, 0, 57);
    drain();                                       // sender waits for every result
    run_phase(40, 0, 57);
    drain();

    configure(18'd0, 18'd1023, 18'd31, 18'd0);
    run_phase(80, 26, 26);
    drain();

    configure(18'h3FFFF, 18'd0, 18'd0, 18'd7);
    run_phase(60, 0, 0);
    drain();

    configure(18'd50, 18'd600, 18'd8, 18'd3);
    hold_reqs++;
    run_phase(100, 26, 26);
    drain();

    if (mismatches == 0) begin
      $display("PASS multi_voice_square_tone_sequencer_unit");
    end else begin
      $display("FAIL multi_voice_square_tone_sequencer_unit");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mvst_pkg.sv
hw/rtl/multi_voice_square_tone_sequencer_unit.sv
verif/multi_voice_square_tone_sequencer_unit_checker.sv
verif/multi_voice_square_tone_sequencer_unit_tb.sv
